// ===== hdl/msq_pkg.sv =====
// ---------------------------------------------------------------------------
// Marching squares package
// Shared transaction types, edge bookkeeping and the segment pattern table.
// ---------------------------------------------------------------------------
package msq_pkg;

   // Threshold of one half in Q1.16.
   localparam logic [16:0] HALF_LEVEL = 17'd32768;

   // Edge slots inside the pipeline payload.
   localparam int EDGE_LEFT   = 0;
   localparam int EDGE_RIGHT  = 1;
   localparam int EDGE_TOP    = 2;
   localparam int EDGE_BOTTOM = 3;
   localparam int NUM_EDGES   = 4;

   // Quotient bits per crossing offset (offset on a crossed edge never exceeds cell_pixels).
   localparam int QUO_BITS = 7;
   localparam int REM_BITS = 24;

   // Segment patterns.
   localparam logic [2:0] PAT_NONE = 3'd0;
   localparam logic [2:0] PAT_LR   = 3'd1;
   localparam logic [2:0] PAT_TB   = 3'd2;
   localparam logic [2:0] PAT_LB   = 3'd3;
   localparam logic [2:0] PAT_BR   = 3'd4;
   localparam logic [2:0] PAT_TR   = 3'd5;
   localparam logic [2:0] PAT_LT   = 3'd6;

   // Pattern for each case code; empty, full and saddle squares give none.
   localparam logic [2:0] PATTERN_TABLE [16] = '{
      PAT_NONE, PAT_LT, PAT_TR, PAT_LR, PAT_LB, PAT_TB, PAT_NONE, PAT_BR,
      PAT_BR, PAT_NONE, PAT_TB, PAT_LB, PAT_LR, PAT_TR, PAT_LT, PAT_NONE
   };

   typedef struct packed {
      logic [9:0]  cell_col;
      logic [9:0]  cell_row;
      logic [16:0] frac_top_left;
      logic [16:0] frac_top_right;
      logic [16:0] frac_bottom_left;
      logic [16:0] frac_bottom_right;
   } req_type;

   typedef struct packed {
      logic        segment_valid;
      logic [3:0]  case_code;
      logic [16:0] start_x;
      logic [16:0] start_y;
      logic [16:0] end_x;
      logic [16:0] end_y;
   } rsp_type;

   // One edge's division in progress.
   typedef struct packed {
      logic [REM_BITS-1:0] rem;
      logic [16:0]         den;
      logic [QUO_BITS-1:0] quo;
   } edge_type;

   // Payload carried between pipeline stages.
   typedef struct packed {
      logic [3:0]            code;
      logic                  in_grid;
      logic [16:0]           x0;
      logic [16:0]           y0;
      edge_type [NUM_EDGES-1:0] edges;
   } stage_type;

endpackage

// ===== hdl/msq_front.sv =====
// ---------------------------------------------------------------------------
// Marching squares front stage
// Classifies corners, scales the cell origin and sets up edge divisions.
// ---------------------------------------------------------------------------
module msq_front #(
   parameter int MAX_GRID = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [6:0]          cell_pixels,
   input  logic                in_valid,
   input  msq_pkg::req_type    in_data,
   output logic                in_ready,
   output logic                out_valid,
   output msq_pkg::stage_type  out_data,
   input  logic                out_ready
);

   logic                valid_ff;
   msq_pkg::stage_type  data_ff;
   msq_pkg::stage_type  data_in;
   logic [16:0]         edge_a [msq_pkg::NUM_EDGES];
   logic [16:0]         edge_b [msq_pkg::NUM_EDGES];

   // Corner pairs of the left, right, top and bottom edges.
   always_comb begin
      edge_a[msq_pkg::EDGE_LEFT]   = in_data.frac_top_left;
      edge_b[msq_pkg::EDGE_LEFT]   = in_data.frac_bottom_left;
      edge_a[msq_pkg::EDGE_RIGHT]  = in_data.frac_top_right;
      edge_b[msq_pkg::EDGE_RIGHT]  = in_data.frac_bottom_right;
      edge_a[msq_pkg::EDGE_TOP]    = in_data.frac_top_left;
      edge_b[msq_pkg::EDGE_TOP]    = in_data.frac_top_right;
      edge_a[msq_pkg::EDGE_BOTTOM] = in_data.frac_bottom_left;
      edge_b[msq_pkg::EDGE_BOTTOM] = in_data.frac_bottom_right;
   end

   // Case code, grid check, origin, and numerator product and denominator for each edge.
   always_comb begin
      logic [16:0] num;
      logic [17:0] org_x;
      logic [17:0] org_y;
      data_in.code[0] = in_data.frac_top_left     >= msq_pkg::HALF_LEVEL;
      data_in.code[1] = in_data.frac_top_right    >= msq_pkg::HALF_LEVEL;
      data_in.code[2] = in_data.frac_bottom_left  >= msq_pkg::HALF_LEVEL;
      data_in.code[3] = in_data.frac_bottom_right >= msq_pkg::HALF_LEVEL;
      data_in.in_grid = (32'(in_data.cell_col) < 32'(MAX_GRID - 1)) &&
                        (32'(in_data.cell_row) < 32'(MAX_GRID - 1));
      org_x = 18'(in_data.cell_col) * 18'(cell_pixels) + 18'(cell_pixels[6:1]);
      org_y = 18'(in_data.cell_row) * 18'(cell_pixels) + 18'(cell_pixels[6:1]);
      data_in.x0 = org_x[16:0];
      data_in.y0 = org_y[16:0];
      for (int i = 0; i < msq_pkg::NUM_EDGES; i++) begin
         num = (edge_a[i] < msq_pkg::HALF_LEVEL) ? (msq_pkg::HALF_LEVEL - edge_a[i])
                                                 : (edge_a[i] - msq_pkg::HALF_LEVEL);
         data_in.edges[i].den = (edge_a[i] < edge_b[i]) ? (edge_b[i] - edge_a[i])
                                                        : (edge_a[i] - edge_b[i]);
         data_in.edges[i].rem = msq_pkg::REM_BITS'(num) *
                                msq_pkg::REM_BITS'(cell_pixels);
         data_in.edges[i].quo = '0;
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // Stage register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== hdl/msq_div_stage.sv =====
// ---------------------------------------------------------------------------
// Marching squares divider stage
// Resolves NUM_BITS quotient bits of the left, right, top and bottom edge divisions.
// ---------------------------------------------------------------------------
module msq_div_stage #(
   parameter int FIRST_BIT = 6,
   parameter int NUM_BITS  = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  msq_pkg::stage_type  in_data,
   output logic                in_ready,
   output logic                out_valid,
   output msq_pkg::stage_type  out_data,
   input  logic                out_ready
);

   logic                valid_ff;
   msq_pkg::stage_type  data_ff;
   msq_pkg::stage_type  data_in;

   // Restoring division steps, most significant quotient bit first.
   always_comb begin
      logic [msq_pkg::REM_BITS-1:0] shifted;
      data_in = in_data;
      for (int e = 0; e < msq_pkg::NUM_EDGES; e++) begin
         for (int i = 0; i < NUM_BITS; i++) begin
            shifted = msq_pkg::REM_BITS'({7'd0, in_data.edges[e].den} << (FIRST_BIT - i));
            if (data_in.edges[e].rem >= shifted) begin
               data_in.edges[e].rem = data_in.edges[e].rem - shifted;
               data_in.edges[e].quo[FIRST_BIT - i] = 1'b1;
            end
         end
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // Stage register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== hdl/msq_select.sv =====
// ---------------------------------------------------------------------------
// Marching squares output stage
// Picks the segment pattern and forms the endpoint pixel coordinates.
// ---------------------------------------------------------------------------
module msq_select (
   input  logic                clock,
   input  logic                reset,
   input  logic [6:0]          cell_pixels,
   input  logic                in_valid,
   input  msq_pkg::stage_type  in_data,
   output logic                in_ready,
   output logic                out_valid,
   output msq_pkg::rsp_type    out_data,
   input  logic                out_stall
);

   logic              valid_ff;
   msq_pkg::rsp_type  data_ff;
   msq_pkg::rsp_type  data_in;

   // Endpoint selection by pattern.
   always_comb begin
      logic [2:0]  pattern;
      logic [16:0] x0;
      logic [16:0] y0;
      logic [16:0] c;
      logic [16:0] lft;
      logic [16:0] rgt;
      logic [16:0] top;
      logic [16:0] bot;
      pattern = msq_pkg::PATTERN_TABLE[in_data.code];
      x0  = in_data.x0;
      y0  = in_data.y0;
      c   = 17'(cell_pixels);
      lft = 17'(in_data.edges[msq_pkg::EDGE_LEFT].quo);
      rgt = 17'(in_data.edges[msq_pkg::EDGE_RIGHT].quo);
      top = 17'(in_data.edges[msq_pkg::EDGE_TOP].quo);
      bot = 17'(in_data.edges[msq_pkg::EDGE_BOTTOM].quo);
      data_in.case_code = in_data.code;
      data_in.segment_valid = (pattern != msq_pkg::PAT_NONE) && in_data.in_grid;
      unique case (pattern)
         msq_pkg::PAT_LR: begin
            data_in.start_x = x0;        data_in.start_y = y0 + lft;
            data_in.end_x   = x0 + c;    data_in.end_y   = y0 + rgt;
         end
         msq_pkg::PAT_TB: begin
            data_in.start_x = x0 + top;  data_in.start_y = y0;
            data_in.end_x   = x0 + bot;  data_in.end_y   = y0 + c;
         end
         msq_pkg::PAT_LB: begin
            data_in.start_x = x0;        data_in.start_y = y0 + lft;
            data_in.end_x   = x0 + bot;  data_in.end_y   = y0 + c;
         end
         msq_pkg::PAT_BR: begin
            data_in.start_x = x0 + bot;  data_in.start_y = y0 + c;
            data_in.end_x   = x0 + c;    data_in.end_y   = y0 + rgt;
         end
         msq_pkg::PAT_TR: begin
            data_in.start_x = x0 + top;  data_in.start_y = y0;
            data_in.end_x   = x0 + c;    data_in.end_y   = y0 + rgt;
         end
         msq_pkg::PAT_LT: begin
            data_in.start_x = x0;        data_in.start_y = y0 + lft;
            data_in.end_x   = x0 + top;  data_in.end_y   = y0;
         end
         default: begin
            data_in.start_x = '0;        data_in.start_y = '0;
            data_in.end_x   = '0;        data_in.end_y   = '0;
         end
      endcase
      // No segment reports zero endpoints.
      if (!data_in.segment_valid) begin
         data_in.start_x = '0;
         data_in.start_y = '0;
         data_in.end_x   = '0;
         data_in.end_y   = '0;
      end
   end

   assign in_ready  = !valid_ff || !out_stall;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== hdl/marching_squares_segment.sv =====
// ---------------------------------------------------------------------------
// Marching squares segment
// Turns one 2x2 square of fill fractions into one isoline segment result.
// ---------------------------------------------------------------------------
//   Channel  Direction  Handshake                Payload
//   req      in         req_valid / req_stall    msq_pkg::req_type
//   rsp      out        rsp_valid / rsp_stall    msq_pkg::rsp_type
//   csr      in         csr_write_enable         cell_pixels, 7 bits
//
// One square is accepted per cycle unless a stall on rsp has backed the pipeline
// up; each result passes through the front stage, four divider stages (two quotient
// bits each, one in the last) and the output register.
// Reset clears all stage valid bits and loads cell_pixels with 8.
// A stall on rsp holds each occupied stage with no empty stage after it; empty stages still fill.
// ---------------------------------------------------------------------------
module marching_squares_segment #(
   parameter int MAX_GRID = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  msq_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output msq_pkg::rsp_type  rsp_data,
   input  logic              csr_write_enable,
   input  logic [6:0]        csr_write_data
);

   localparam int NUM_DIV = 4;

   logic [6:0]          cell_pixels_ff;
   logic                front_ready;
   logic                stg_valid [NUM_DIV+1];
   logic                stg_ready [NUM_DIV+1];
   msq_pkg::stage_type  stg_data  [NUM_DIV+1];

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         cell_pixels_ff <= 7'd8;
      end else if (csr_write_enable) begin
         cell_pixels_ff <= csr_write_data;
      end
   end

   assign req_stall = !front_ready;

   // Corner classification and division setup.
   msq_front #(
      .MAX_GRID (MAX_GRID)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cell_pixels (cell_pixels_ff),
      .in_valid    (req_valid),
      .in_data     (req_data),
      .in_ready    (front_ready),
      .out_valid   (stg_valid[0]),
      .out_data    (stg_data[0]),
      .out_ready   (stg_ready[0])
   );

   // Divider pipeline.
   for (genvar s = 0; s < NUM_DIV; s++) begin : g_div
      localparam int FIRST = msq_pkg::QUO_BITS - 1 - 2 * s;
      localparam int COUNT = (FIRST >= 1) ? 2 : 1;
      msq_div_stage #(
         .FIRST_BIT (FIRST),
         .NUM_BITS  (COUNT)
      ) u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stg_valid[s]),
         .in_data   (stg_data[s]),
         .in_ready  (stg_ready[s]),
         .out_valid (stg_valid[s+1]),
         .out_data  (stg_data[s+1]),
         .out_ready (stg_ready[s+1])
      );
   end

   // Pattern selection and output register.
   msq_select u_select (
      .clock       (clock),
      .reset       (reset),
      .cell_pixels (cell_pixels_ff),
      .in_valid    (stg_valid[NUM_DIV]),
      .in_data     (stg_data[NUM_DIV]),
      .in_ready    (stg_ready[NUM_DIV]),
      .out_valid   (rsp_valid),
      .out_data    (rsp_data),
      .out_stall   (rsp_stall)
   );

   // A segment is never reported for empty, full or saddle squares.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.segment_valid |->
         msq_pkg::PATTERN_TABLE[rsp_data.case_code] != msq_pkg::PAT_NONE)
      else $error("segment reported for a square without a pattern");

   // A result without a segment carries zero endpoints.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.segment_valid |->
         rsp_data.start_x == '0 && rsp_data.start_y == '0 &&
         rsp_data.end_x == '0 && rsp_data.end_y == '0)
      else $error("endpoints not cleared for a square without a segment");

   // Reset empties the pipeline.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // The input is only held off while the pipeline is backed up.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled while output is free");

endmodule

// ===== bench/marching_squares_segment_tb.sv =====
// ---------------------------------------------------------------------------
// Marching squares segment testbench
// Streams squares through the block under random idling on both channels,
// predicts each segment result from the corner fractions and the cell size,
// and checks every result in order against the prediction.
// ---------------------------------------------------------------------------

// Holds predicted results in arrival order and compares accepted results.
class segment_scoreboard;
   msq_pkg::rsp_type pending[$];
   logic [6:0]       cell_pixels;
   int               errors;

   function new();
      cell_pixels = 7'd8;
      errors      = 0;
   endfunction

   // Crossing offset along one edge, floored.
   function automatic logic [16:0] crossing(logic [16:0] a, logic [16:0] b);
      logic [31:0] num;
      logic [31:0] den;
      num = (a < msq_pkg::HALF_LEVEL) ? 32'(msq_pkg::HALF_LEVEL - a)
                                      : 32'(a - msq_pkg::HALF_LEVEL);
      den = (a < b) ? 32'(b - a) : 32'(a - b);
      if (den == 0) return 17'd0;
      return 17'((num * 32'(cell_pixels)) / den);
   endfunction

   // Predict the segment for one accepted square.
   function void note_square(msq_pkg::req_type sq);
      msq_pkg::rsp_type exp_seg;
      logic [16:0] c, x0, y0, lft, rgt, top, bot;
      logic [3:0]  code;
      logic        ok;
      c = 17'(cell_pixels);
      code = {sq.frac_bottom_right >= msq_pkg::HALF_LEVEL,
              sq.frac_bottom_left >= msq_pkg::HALF_LEVEL,
              sq.frac_top_right >= msq_pkg::HALF_LEVEL,
              sq.frac_top_left >= msq_pkg::HALF_LEVEL};
      x0  = 17'(32'(sq.cell_col) * 32'(cell_pixels) + 32'(cell_pixels / 7'd2));
      y0  = 17'(32'(sq.cell_row) * 32'(cell_pixels) + 32'(cell_pixels / 7'd2));
      lft = crossing(sq.frac_top_left, sq.frac_bottom_left);
      rgt = crossing(sq.frac_top_right, sq.frac_bottom_right);
      top = crossing(sq.frac_top_left, sq.frac_top_right);
      bot = crossing(sq.frac_bottom_left, sq.frac_bottom_right);
      exp_seg = '0;
      exp_seg.case_code = code;
      ok = 1'b1;
      case (msq_pkg::PATTERN_TABLE[code])
         msq_pkg::PAT_LR: begin
            exp_seg.start_x = x0; exp_seg.start_y = y0 + lft;
            exp_seg.end_x = x0 + c; exp_seg.end_y = y0 + rgt;
         end
         msq_pkg::PAT_TB: begin
            exp_seg.start_x = x0 + top; exp_seg.start_y = y0;
            exp_seg.end_x = x0 + bot; exp_seg.end_y = y0 + c;
         end
         msq_pkg::PAT_LB: begin
            exp_seg.start_x = x0; exp_seg.start_y = y0 + lft;
            exp_seg.end_x = x0 + bot; exp_seg.end_y = y0 + c;
         end
         msq_pkg::PAT_BR: begin
            exp_seg.start_x = x0 + bot; exp_seg.start_y = y0 + c;
            exp_seg.end_x = x0 + c; exp_seg.end_y = y0 + rgt;
         end
         msq_pkg::PAT_TR: begin
            exp_seg.start_x = x0 + top; exp_seg.start_y = y0;
            exp_seg.end_x = x0 + c; exp_seg.end_y = y0 + rgt;
         end
         msq_pkg::PAT_LT: begin
            exp_seg.start_x = x0; exp_seg.start_y = y0 + lft;
            exp_seg.end_x = x0 + top; exp_seg.end_y = y0;
         end
         default: ok = 1'b0;
      endcase
      // Squares on the last row or column of the grid give no segment.
      if (sq.cell_col >= 10'd1023 || sq.cell_row >= 10'd1023) ok = 1'b0;
      if (!ok) begin
         exp_seg.start_x = '0; exp_seg.start_y = '0;
         exp_seg.end_x = '0; exp_seg.end_y = '0;
      end
      exp_seg.segment_valid = ok;
      pending.push_back(exp_seg);
   endfunction

   task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch on %s: got %0d, expected %0d", what, got, want);
      errors++;
   endtask

   // Compare one accepted result with the oldest prediction.
   task check_segment(msq_pkg::rsp_type got);
      msq_pkg::rsp_type want;
      if (pending.size() == 0) begin
         $display("unexpected segment result %h", got);
         errors++;
      end else begin
         want = pending.pop_front();
         if (got.segment_valid !== want.segment_valid)
            report("segment_valid", 32'(got.segment_valid), 32'(want.segment_valid));
         if (got.case_code !== want.case_code)
            report("case_code", 32'(got.case_code), 32'(want.case_code));
         if (got.start_x !== want.start_x)
            report("start_x", 32'(got.start_x), 32'(want.start_x));
         if (got.start_y !== want.start_y)
            report("start_y", 32'(got.start_y), 32'(want.start_y));
         if (got.end_x !== want.end_x)
            report("end_x", 32'(got.end_x), 32'(want.end_x));
         if (got.end_y !== want.end_y)
            report("end_y", 32'(got.end_y), 32'(want.end_y));
      end
   endtask
endclass

module marching_squares_segment_tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   msq_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   msq_pkg::rsp_type rsp_data;
   logic             csr_write_enable = 1'b0;
   logic [6:0]       csr_write_data = '0;
   logic             idle_allowed = 1'b1;
   logic             bench_done = 1'b0;

   segment_scoreboard board = new();

   marching_squares_segment u_top (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data, .csr_write_enable, .csr_write_data
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Sample both channels at the rising edge.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) board.note_square(req_data);
      if (!reset && rsp_valid && !rsp_stall) board.check_segment(rsp_data);
   end

   // Receiver stall in random bursts.
   initial begin
      int n;
      @(negedge clock);
      while (!bench_done) begin
         if (idle_allowed && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 13);
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 20)) @(negedge clock);
      end
   end

   function automatic logic [16:0] pick_frac();
      case ($urandom_range(0, 9))
         0: return 17'd0;
         1: return 17'd65536;
         2: return 17'd32768;
         3: return 17'd32767;
         4: return 17'($urandom_range(65537, 131071));
         default: return 17'($urandom_range(0, 65536));
      endcase
   endfunction

   function automatic msq_pkg::req_type random_square();
      msq_pkg::req_type sq;
      sq.cell_col = ($urandom_range(0, 15) == 0) ? 10'($urandom) : 10'($urandom_range(0, 40));
      sq.cell_row = ($urandom_range(0, 15) == 0) ? 10'($urandom) : 10'($urandom_range(0, 40));
      sq.frac_top_left     = pick_frac();
      sq.frac_top_right    = pick_frac();
      sq.frac_bottom_left  = pick_frac();
      sq.frac_bottom_right = pick_frac();
      return sq;
   endfunction

   // Offer one square, possibly after an idle burst, and hold until accepted.
   task send_square(msq_pkg::req_type sq);
      if (idle_allowed && $urandom_range(0, 6) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= sq;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // Drain, let the pipeline settle, then write the cell size.
   task set_cell_pixels(logic [6:0] value);
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      board.cell_pixels = value;
   endtask

   task directed_squares();
      msq_pkg::req_type sq;
      for (int code = 0; code < 16; code++) begin
         sq.cell_col = 10'(code);
         sq.cell_row = 10'(15 - code);
         sq.frac_top_left     = code[0] ? 17'd65536 : 17'd0;
         sq.frac_top_right    = code[1] ? 17'd40000 : 17'd12345;
         sq.frac_bottom_left  = code[2] ? 17'd32768 : 17'd32767;
         sq.frac_bottom_right = code[3] ? 17'd131071 : 17'd1;
         send_square(sq);
      end
      sq = '{10'd1023, 10'd5, 17'd65536, 17'd0, 17'd65536, 17'd0};
      send_square(sq);
      sq = '{10'd5, 10'd1022, 17'd65536, 17'd0, 17'd65536, 17'd0};
      send_square(sq);
      sq = '{10'd1022, 10'd1021, 17'd0, 17'd65536, 17'd0, 17'd65536};
      send_square(sq);
      sq = '{10'd1021, 10'd1022, 17'd40000, 17'd40000, 17'd40000, 17'd1};
      send_square(sq);
      sq = '{10'd0, 10'd0, 17'h1FFFF, 17'h1FFFF, 17'd0, 17'd0};
      send_square(sq);
   endtask

   initial begin
      logic [6:0] sizes[6];
      sizes = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd37, 7'd8};
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      directed_squares();
      for (int p = 0; p < 6; p++) begin
         set_cell_pixels(sizes[p]);
         directed_squares();
         if (p == 5) idle_allowed = 1'b0;
         for (int i = 0; i < 240; i++) begin
            if (p == 4 && i == 200) idle_allowed = 1'b0;
            send_square(random_square());
         end
      end
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      bench_done = 1'b1;
      if (board.errors == 0 && board.pending.size() == 0)
         $display("marching_squares_segment_tb passed");
      else
         $display("marching_squares_segment_tb failed");
      $finish;
   end

   initial begin
      #400000;
      $display("marching_squares_segment_tb failed");
      $finish;
   end
endmodule

// ===== marching_squares_segment.f =====
hdl/msq_pkg.sv
hdl/msq_front.sv
hdl/msq_div_stage.sv
hdl/msq_select.sv
hdl/marching_squares_segment.sv
bench/marching_squares_segment_tb.sv
